// ===== sv/rlse_pkg.sv =====
// ----------------------------------------------------------------------------
// rlse_pkg
// Shared types, constants and the SPI bit encoder for the LED ring frame encoder.
// ----------------------------------------------------------------------------
package rlse_pkg;

	localparam int NUM_LEDS_DEF = 16;

	localparam int LED_CNT_W = 5;
	localparam int CODE_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_IDX_W = 4;
	localparam int COLOR_W   = 8;
	localparam int PIXEL_W   = 3 * COLOR_W;
	localparam int WORD_W    = 8 * CODE_W;

	localparam logic [LED_CNT_W-1:0] LED_COUNT_RST = 5'd16;
	localparam logic [CODE_W-1:0]    CODE_ZERO_RST = 8'hC0;
	localparam logic [CODE_W-1:0]    CODE_ONE_RST  = 8'hFC;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_SHOW   = 3'd1,
		OP_ROTATE = 3'd2,
		OP_BLANK  = 3'd3,
		OP_CLEAR  = 3'd4
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LED_COUNT = 2'd0,
		REG_CODE_ZERO = 2'd1,
		REG_CODE_ONE  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	typedef enum logic [1:0] {
		COL_GREEN = 2'd0,
		COL_RED   = 2'd1,
		COL_BLUE  = 2'd2
	} color_t;

	typedef struct packed {
		logic                 wr_en;
		logic                 clr;
		logic [PIX_IDX_W-1:0] wr_idx;
		logic [PIXEL_W-1:0]   wr_px;
	} store_cmd_t;

	// Each color bit becomes one SPI byte, MSB first in the top byte.
	function automatic logic [WORD_W-1:0] encode_byte(
		input logic [COLOR_W-1:0] c,
		input logic [CODE_W-1:0]  code0,
		input logic [CODE_W-1:0]  code1
	);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < COLOR_W; i++) begin
			w[i*CODE_W +: CODE_W] = c[i] ? code1 : code0;
		end
		return w;
	endfunction

endpackage

// ===== sv/rlse_if.sv =====
// ----------------------------------------------------------------------------
// rlse_if
// Request channels of the LED ring frame encoder: commands in, SPI words out.
// ----------------------------------------------------------------------------
interface rlse_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [3:0] pixel_index;
	logic [7:0] green;
	logic [7:0] red;
	logic [7:0] blue;

	modport source (output valid, output opcode, output pixel_index,
		output green, output red, output blue, input ready);
	modport sink (input valid, input opcode, input pixel_index,
		input green, input red, input blue, output ready);
endinterface

interface rlse_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] spi_word;
	logic        last;

	modport source (output valid, output spi_word, output last, input ready);
	modport sink (input valid, input spi_word, input last, output ready);
endinterface

// ===== sv/rgb_led_ring_spi_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// rgb_led_ring_spi_frame_encoder
// Stores a ring of GRB pixels and streams rotated frames as SPI-coded words.
// Show, rotate and blank are taken when idle, then NUM_LEDS*3 words (48 at
// default) follow, one per cycle while the receiver takes them, from a single
// slot/encode datapath stepped by a position and color counter; not ready
// until the last word is loaded. Write and clear emit nothing.
// arst_n clears pixels, rotation and sequencer; registers take reset values.
// ----------------------------------------------------------------------------
module rgb_led_ring_spi_frame_encoder #(
	parameter int NUM_LEDS = rlse_pkg::NUM_LEDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rlse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rlse_pkg::CODE_W-1:0]    cfg_data,
	rlse_cmd_if.sink                       cmd,
	rlse_word_if.source                    word
);
	import rlse_pkg::*;

	localparam int SLOT_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_LEDS - 1);
	localparam logic [SLOT_W:0]   NUM_EXT   = (SLOT_W + 1)'(NUM_LEDS);

	logic [LED_CNT_W-1:0] led_count_q;
	logic [CODE_W-1:0]    code_zero_q;
	logic [CODE_W-1:0]    code_one_q;

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] rot_q;
	logic [SLOT_W-1:0] pos_q;
	color_t            color_q;
	logic              blank_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_last_q;

	logic               accept;
	logic               start;
	logic               load;
	logic               is_last;
	logic [SLOT_W:0]    slot_ext;
	logic [SLOT_W-1:0]  slot;
	logic [PIXEL_W-1:0] rd_px;
	logic [PIXEL_W-1:0] px;
	logic [COLOR_W-1:0] color_byte;
	store_cmd_t         store_cmd;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign start     = accept && (cmd.opcode == OP_SHOW || cmd.opcode == OP_ROTATE
		|| cmd.opcode == OP_BLANK);
	assign load      = (state_q == ST_SEND) && (!out_valid_q || word.ready);
	assign is_last   = (pos_q == LAST_SLOT) && (color_q == COL_BLUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_COUNT_RST;
			code_zero_q <= CODE_ZERO_RST;
			code_one_q  <= CODE_ONE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LED_COUNT: led_count_q <= cfg_data[LED_CNT_W-1:0];
				REG_CODE_ZERO: code_zero_q <= cfg_data;
				REG_CODE_ONE:  code_one_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign store_cmd.wr_en  = accept && (cmd.opcode == OP_WRITE)
		&& (32'(cmd.pixel_index) < NUM_LEDS);
	assign store_cmd.clr    = accept && (cmd.opcode == OP_CLEAR);
	assign store_cmd.wr_idx = cmd.pixel_index;
	assign store_cmd.wr_px  = {cmd.green, cmd.red, cmd.blue};

	rlse_pixel_store #(
		.NUM_LEDS (NUM_LEDS),
		.SLOT_W   (SLOT_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (store_cmd),
		.rd_slot (slot),
		.rd_px   (rd_px)
	);

	always_comb begin
		if (pos_q >= rot_q) begin
			slot_ext = {1'b0, pos_q} - {1'b0, rot_q};
		end else begin
			slot_ext = {1'b0, pos_q} + NUM_EXT - {1'b0, rot_q};
		end
		slot = slot_ext[SLOT_W-1:0];
		px = (!blank_q && (32'(slot) < 32'(led_count_q))) ? rd_px : '0;
		case (color_q)
			COL_GREEN: color_byte = px[23:16];
			COL_RED:   color_byte = px[15:8];
			default:   color_byte = px[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (load && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q   <= '0;
			pos_q   <= '0;
			color_q <= COL_GREEN;
			blank_q <= 1'b0;
		end else if (start) begin
			pos_q   <= '0;
			color_q <= COL_GREEN;
			blank_q <= (cmd.opcode == OP_BLANK);
			if (cmd.opcode == OP_BLANK) begin
				rot_q <= '0;
			end else if (cmd.opcode == OP_ROTATE) begin
				rot_q <= (rot_q == LAST_SLOT) ? '0 : rot_q + 1'b1;
			end
		end else if (load) begin
			if (color_q == COL_BLUE) begin
				color_q <= COL_GREEN;
				pos_q   <= is_last ? '0 : pos_q + 1'b1;
			end else begin
				color_q <= color_t'(color_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (word.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q <= encode_byte(color_byte, code_zero_q, code_one_q);
			out_last_q <= is_last;
		end
	end

	assign word.valid    = out_valid_q;
	assign word.spi_word = out_word_q;
	assign word.last     = out_last_q;

`ifndef SYNTHESIS
	a_start_sends: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == ST_SEND)
		else $error("frame request did not start sending");
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rot_q) < NUM_LEDS && 32'(pos_q) < NUM_LEDS)
		else $error("rotation or position out of range");
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		load && is_last |=> out_valid_q && out_last_q && state_q == ST_IDLE)
		else $error("last word not flagged at frame end");
`endif

endmodule

// ===== sv/rlse_pixel_store.sv =====
// ----------------------------------------------------------------------------
// rlse_pixel_store
// Pixel registers with single write, clear-all and one read port.
// ----------------------------------------------------------------------------
module rlse_pixel_store #(
	parameter int NUM_LEDS = rlse_pkg::NUM_LEDS_DEF,
	parameter int SLOT_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rlse_pkg::store_cmd_t         cmd,
	input  logic [SLOT_W-1:0]            rd_slot,
	output logic [rlse_pkg::PIXEL_W-1:0] rd_px
);
	import rlse_pkg::*;

	logic [PIXEL_W-1:0] px_q [NUM_LEDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				px_q[i] <= '0;
			end
		end else if (cmd.clr) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				px_q[i] <= '0;
			end
		end else if (cmd.wr_en) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				if (32'(cmd.wr_idx) == i) begin
					px_q[i] <= cmd.wr_px;
				end
			end
		end
	end

	assign rd_px = px_q[rd_slot];

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the LED ring frame encoder. Commands go in through the
// request channel while an internal predictor tracks the pixel store,
// rotation and code registers. Every SPI word that comes out is compared
// against the predicted frame. The run covers directed cases, random
// command mixes, a full rotation sweep and several register settings,
// with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rlse_pkg::*;

	localparam int SLOTS = NUM_LEDS_DEF;

	class led_frame_model;
		typedef struct packed {
			logic [WORD_W-1:0] spi_word;
			logic              last;
		} spi_beat_t;

		logic [PIXEL_W-1:0]   pixels [SLOTS];
		int                   rotation;
		logic [LED_CNT_W-1:0] led_count;
		logic [CODE_W-1:0]    code0;
		logic [CODE_W-1:0]    code1;
		spi_beat_t            pending_words [$];
		int                   words_seen;
		int                   errors;

		function new();
			foreach (pixels[i]) pixels[i] = '0;
			rotation   = 0;
			led_count  = LED_COUNT_RST;
			code0      = CODE_ZERO_RST;
			code1      = CODE_ONE_RST;
			words_seen = 0;
			errors     = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [7:0] data);
			case (idx)
				REG_LED_COUNT: led_count = data[LED_CNT_W-1:0];
				REG_CODE_ZERO: code0 = data;
				REG_CODE_ONE:  code1 = data;
				default: ;
			endcase
		endfunction

		function void push_frame(bit blank);
			int                 slot;
			logic [PIXEL_W-1:0] px;
			logic [COLOR_W-1:0] colour;
			spi_beat_t          beat;
			for (int q = 0; q < SLOTS; q++) begin
				slot = (q + SLOTS - rotation) % SLOTS;
				px = (!blank && slot < led_count) ? pixels[slot] : '0;
				for (int c = 0; c < 3; c++) begin
					colour = px[PIXEL_W-1-COLOR_W*c -: COLOR_W];
					beat.spi_word = '0;
					for (int b = COLOR_W - 1; b >= 0; b--)
						beat.spi_word = {beat.spi_word[WORD_W-CODE_W-1:0],
							colour[b] ? code1 : code0};
					beat.last = (q == SLOTS - 1) && (c == 2);
					pending_words.push_back(beat);
				end
			end
		endfunction

		function void take_command(logic [2:0] op, logic [3:0] idx,
			logic [7:0] g, logic [7:0] r, logic [7:0] b);
			case (op)
				OP_WRITE:  pixels[idx] = {g, r, b};
				OP_SHOW:   push_frame(0);
				OP_ROTATE: begin
					rotation = (rotation + 1) % SLOTS;
					push_frame(0);
				end
				OP_BLANK: begin
					rotation = 0;
					push_frame(1);
				end
				OP_CLEAR:  foreach (pixels[i]) pixels[i] = '0;
				default: ;
			endcase
		endfunction

		function void check_word(logic [WORD_W-1:0] spi_word, logic last);
			spi_beat_t exp_beat;
			words_seen++;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word %h last %b", $time, spi_word, last);
				errors++;
				return;
			end
			exp_beat = pending_words.pop_front();
			if (spi_word !== exp_beat.spi_word) begin
				$display("%0t: word %0d spi_word expected %h, actual %h", $time,
					words_seen, exp_beat.spi_word, spi_word);
				errors++;
			end
			if (last !== exp_beat.last) begin
				$display("%0t: word %0d last expected %b, actual %b", $time,
					words_seen, exp_beat.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0] cfg_data;

	rlse_cmd_if  cmd_ch ();
	rlse_word_if word_ch ();

	rgb_led_ring_spi_frame_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.word      (word_ch)
	);

	led_frame_model ledm = new();
	int             burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: stall pattern picks a new random mode for each random-length run
	initial begin
		int mode;
		int len;
		word_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(8, 60);
			for (int k = 0; k < len; k++) begin
				@(negedge clk);
				case (mode)
					0: word_ch.ready <= 1'b1;
					1: word_ch.ready <= 1'($urandom_range(0, 1));
					2: word_ch.ready <= ($urandom_range(0, 3) == 0);
					default: word_ch.ready <= (k >= len - 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && word_ch.valid && word_ch.ready)
			ledm.check_word(word_ch.spi_word, word_ch.last);
	end

	function automatic logic [7:0] rand_colour();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [7:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		ledm.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_command(logic [2:0] op, logic [3:0] idx,
		logic [7:0] g, logic [7:0] r, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid       <= 1'b1;
		cmd_ch.opcode      <= op;
		cmd_ch.pixel_index <= idx;
		cmd_ch.green       <= g;
		cmd_ch.red         <= r;
		cmd_ch.blue        <= b;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		ledm.take_command(op, idx, g, r, b);
	endtask

	task automatic send_op(opcode_t op);
		send_command(op, 4'($urandom_range(0, 15)), rand_colour(), rand_colour(),
			rand_colour());
	endtask

	task automatic wait_frames_done();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (ledm.pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_mix(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_op(OP_WRITE);
			else if (pick < 65)
				send_op(OP_SHOW);
			else if (pick < 82)
				send_op(OP_ROTATE);
			else if (pick < 88)
				send_op(OP_BLANK);
			else if (pick < 93)
				send_op(OP_CLEAR);
			else
				send_command(3'($urandom_range(5, 7)), 4'($urandom_range(0, 15)),
					rand_colour(), rand_colour(), rand_colour());
		end
	endtask

	task automatic run_rotation_sweep();
		repeat (3) send_op(OP_WRITE);
		repeat (17) send_op(OP_ROTATE);
		send_op(OP_SHOW);
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_LED_COUNT;
		cfg_data           = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.opcode      = OP_WRITE;
		cmd_ch.pixel_index = '0;
		cmd_ch.green       = '0;
		cmd_ch.red         = '0;
		cmd_ch.blue        = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset registers
		send_op(OP_SHOW);
		send_command(OP_WRITE, 4'd0, 8'hFF, 8'h00, 8'hFF);
		send_command(OP_WRITE, 4'd15, 8'h00, 8'hFF, 8'h00);
		send_command(OP_WRITE, 4'd5, 8'hA5, 8'h5A, 8'hC3);
		send_op(OP_SHOW);
		send_op(OP_ROTATE);
		send_op(OP_ROTATE);
		send_op(OP_BLANK);
		send_op(OP_SHOW);
		send_command(3'd5, 4'd3, 8'h12, 8'h34, 8'h56);
		send_command(3'd6, 4'd0, 8'hFF, 8'hFF, 8'hFF);
		send_command(3'd7, 4'd15, 8'h00, 8'h00, 8'h00);
		send_op(OP_SHOW);
		send_op(OP_CLEAR);
		send_op(OP_SHOW);
		send_command(OP_WRITE, 4'd10, 8'hFF, 8'hFF, 8'hFF);
		send_op(OP_ROTATE);
		send_op(OP_CLEAR);
		send_op(OP_ROTATE);
		send_op(OP_BLANK);

		wait_frames_done();
		write_reg(REG_LED_COUNT, 8'h00);
		write_reg(REG_CODE_ZERO, 8'h00);
		write_reg(REG_CODE_ONE, 8'hFF);
		run_mix(22);

		wait_frames_done();
		write_reg(REG_LED_COUNT, 8'hFF);
		write_reg(REG_CODE_ZERO, 8'hFF);
		write_reg(REG_CODE_ONE, 8'h00);
		run_mix(22);

		wait_frames_done();
		write_reg(REG_LED_COUNT, 8'd1);
		write_reg(REG_CODE_ZERO, 8'($urandom_range(0, 255)));
		write_reg(REG_CODE_ONE, 8'($urandom_range(0, 255)));
		run_mix(22);

		wait_frames_done();
		write_reg(REG_LED_COUNT, 8'd16);
		write_reg(REG_CODE_ZERO, CODE_ZERO_RST);
		write_reg(REG_CODE_ONE, CODE_ONE_RST);
		run_rotation_sweep();

		wait_frames_done();
		write_reg(REG_LED_COUNT, {3'($urandom_range(0, 7)), 5'($urandom_range(2, 15))});
		write_reg(REG_CODE_ZERO, 8'($urandom_range(0, 255)));
		write_reg(REG_CODE_ONE, 8'($urandom_range(0, 255)));
		run_mix(22);

		wait_frames_done();
		write_reg(REG_LED_COUNT, 8'd17);
		write_reg(REG_CODE_ZERO, 8'($urandom_range(0, 255)));
		write_reg(REG_CODE_ONE, 8'($urandom_range(0, 255)));
		run_mix(22);

		wait_frames_done();
		repeat (20) @(posedge clk);
		if (ledm.errors == 0 && ledm.pending_words.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/rlse_pkg.sv
sv/rlse_if.sv
sv/rlse_pixel_store.sv
sv/rgb_led_ring_spi_frame_encoder.sv
dv/tb.sv
